// ----- hdl/particle_bounce_step_macros.svh -----
// Assertion helpers for the particle step pipeline.
// Both expect clk and arst_n in the enclosing module.
`ifndef PARTICLE_BOUNCE_STEP_MACROS_SVH
`define PARTICLE_BOUNCE_STEP_MACROS_SVH

// Condition that must hold at every clock outside reset
`define PBS_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define PBS_CHECK_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/pbs_pkg.sv -----
`default_nettype none

package pbs_pkg;

	// field geometry
	localparam int FieldMaxX   = 79;
	localparam int FieldMaxY   = 15;
	localparam int VelBound    = 80;
	localparam int CellW       = 5;
	localparam int CellH       = 8;
	localparam int CellsPerRow = 16;
	// reciprocal of CellW scaled by 2^10, exact for x below 128
	localparam int Div5Mul     = 205;

	// register indexes
	localparam logic [1:0] CFG_GRAVITY = 2'd0;
	localparam logic [1:0] CFG_LOSS    = 2'd1;
	localparam logic [1:0] CFG_LIMIT   = 2'd2;

	// effective configuration seen by the datapath
	typedef struct packed {
		logic [2:0] gravity;
		logic [2:0] loss;
		logic [6:0] lim;
	} pbs_cfg_t;

	typedef struct packed {
		logic [2:0]        kick_y;
		logic [2:0]        kick_x;
		logic signed [7:0] vel_y;
		logic signed [7:0] vel_x;
		logic [3:0]        pos_y;
		logic [6:0]        pos_x;
	} pbs_in_t;

	// after gravity and velocity clamp
	typedef struct packed {
		logic [2:0]        kick_y;
		logic [2:0]        kick_x;
		logic signed [7:0] vel_y;
		logic signed [7:0] vel_x;
		logic [3:0]        pos_y;
		logic [6:0]        pos_x;
	} pbs_s1_t;

	// after move and bounce, wide values
	typedef struct packed {
		logic [2:0]        kick_y;
		logic [2:0]        kick_x;
		logic signed [9:0] vel_y;
		logic signed [9:0] vel_x;
		logic signed [9:0] pos_y;
		logic signed [9:0] pos_x;
	} pbs_s2_t;

	// resolved particle
	typedef struct packed {
		logic signed [7:0] vel_y;
		logic signed [7:0] vel_x;
		logic [3:0]        pos_y;
		logic [6:0]        pos_x;
	} pbs_s3_t;

	typedef struct packed {
		logic [4:0]        cell_index;
		logic [2:0]        dot_row;
		logic [2:0]        dot_col;
		logic              cell_row;
		logic [3:0]        cell_col;
		logic signed [7:0] new_vel_y;
		logic signed [7:0] new_vel_x;
		logic [3:0]        new_pos_y;
		logic [6:0]        new_pos_x;
	} pbs_out_t;

	// saturate a wide velocity to -lim..lim
	function automatic logic signed [7:0] sat_vel(input logic signed [9:0] v,
		input logic [6:0] lim);
		logic signed [9:0] l;
		logic signed [9:0] r;
		l = $signed({3'b000, lim});
		if (v > l) begin
			r = l;
		end else if (v < -l) begin
			r = -l;
		end else begin
			r = v;
		end
		return r[7:0];
	endfunction

endpackage

`default_nettype wire

// ----- hdl/pbs_cfg.sv -----
`default_nettype none

module pbs_cfg
	import pbs_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [6:0] cfg_data,
	output pbs_cfg_t        cfg
);

	logic [2:0] gravity_q;
	logic [2:0] loss_q;
	logic [6:0] limit_q;

	assign cfg_ready = 1'b1;

	// register writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q <= 3'd1;
			loss_q    <= 3'd1;
			limit_q   <= 7'(VelBound);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GRAVITY: gravity_q <= cfg_data[2:0];
				CFG_LOSS:    loss_q    <= cfg_data[2:0];
				CFG_LIMIT:   limit_q   <= cfg_data;
				default:     ;
			endcase
		end
	end

	// effective limit saturates at the velocity bound
	always_comb begin
		cfg.gravity = gravity_q;
		cfg.loss    = loss_q;
		cfg.lim     = (limit_q > 7'(VelBound)) ? 7'(VelBound) : limit_q;
	end

endmodule

`default_nettype wire

// ----- hdl/pbs_move.sv -----
`default_nettype none

module pbs_move
	import pbs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire logic     v_in,
	input  wire pbs_in_t  d_in,
	input  wire pbs_cfg_t cfg,
	output logic          v_s2,
	output pbs_s2_t       d_s2
);

	logic              v_s1;
	pbs_s1_t           d_s1;
	logic signed [9:0] vy_grav;
	logic signed [9:0] vx_w;
	logic signed [9:0] vy_w;
	logic signed [9:0] px_w;
	logic signed [9:0] py_w;
	logic signed [9:0] loss_w;
	logic signed [9:0] vx_b;
	logic signed [9:0] vy_b;

	// stage 1: gravity and velocity clamp
	assign vy_grav = $signed({{2{d_in.vel_y[7]}}, d_in.vel_y}) - $signed({7'b0, cfg.gravity});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_in) begin
			d_s1.pos_x  <= d_in.pos_x;
			d_s1.pos_y  <= d_in.pos_y;
			d_s1.vel_x  <= sat_vel($signed({{2{d_in.vel_x[7]}}, d_in.vel_x}), cfg.lim);
			d_s1.vel_y  <= sat_vel(vy_grav, cfg.lim);
			d_s1.kick_x <= d_in.kick_x;
			d_s1.kick_y <= d_in.kick_y;
		end
	end

	// stage 2: move, then bounce off any reached wall
	always_comb begin
		vx_w   = $signed({{2{d_s1.vel_x[7]}}, d_s1.vel_x});
		vy_w   = $signed({{2{d_s1.vel_y[7]}}, d_s1.vel_y});
		loss_w = $signed({7'b0, cfg.loss});
		px_w   = $signed({3'b0, d_s1.pos_x}) + vx_w;
		py_w   = $signed({6'b0, d_s1.pos_y}) - vy_w;
		vx_b   = vx_w;
		vy_b   = vy_w;
		if (px_w <= 10'sd0 && vx_w < 10'sd0) begin
			vx_b = -vx_w - loss_w;
		end else if (px_w >= 10'(FieldMaxX) && vx_w > 10'sd0) begin
			vx_b = -vx_w + loss_w;
		end
		if (py_w <= 10'sd0 && vy_w > 10'sd0) begin
			vy_b = -vy_w + loss_w;
		end else if (py_w >= 10'(FieldMaxY) && vy_w < 10'sd0) begin
			vy_b = -vy_w - loss_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			d_s2.pos_x  <= px_w;
			d_s2.pos_y  <= py_w;
			d_s2.vel_x  <= vx_b;
			d_s2.vel_y  <= vy_b;
			d_s2.kick_x <= d_s1.kick_x;
			d_s2.kick_y <= d_s1.kick_y;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/pbs_resolve.sv -----
`default_nettype none

module pbs_resolve
	import pbs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire logic     v_in,
	input  wire pbs_s2_t  d_in,
	input  wire pbs_cfg_t cfg,
	output logic          v_s3,
	output pbs_s3_t       d_s3
);

`include "particle_bounce_step_macros.svh"

	logic signed [7:0] vx_c;
	logic signed [7:0] vy_c;
	logic signed [7:0] vx_f;
	logic signed [7:0] vx_n;
	logic signed [7:0] vy_n;
	logic [6:0]        px_n;
	logic [3:0]        py_n;
	logic              floor_hit;
	logic signed [7:0] lim_s;

	assign lim_s = $signed({1'b0, cfg.lim});

	// clamp, floor friction, kick for a resting particle
	always_comb begin
		vx_c = sat_vel(d_in.vel_x, cfg.lim);
		vy_c = sat_vel(d_in.vel_y, cfg.lim);
		priority if (d_in.pos_x < 10'sd0) begin
			px_n = 7'd0;
		end else if (d_in.pos_x > 10'(FieldMaxX)) begin
			px_n = 7'(FieldMaxX);
		end else begin
			px_n = d_in.pos_x[6:0];
		end
		priority if (d_in.pos_y < 10'sd0) begin
			py_n = 4'd0;
		end else if (d_in.pos_y > 10'(FieldMaxY)) begin
			py_n = 4'(FieldMaxY);
		end else begin
			py_n = d_in.pos_y[3:0];
		end
		floor_hit = (d_in.pos_y >= 10'(FieldMaxY));
		vx_f = vx_c;
		if (floor_hit) begin
			if (vx_c < 8'sd0) begin
				vx_f = vx_c + 8'sd1;
			end else if (vx_c > 8'sd0) begin
				vx_f = vx_c - 8'sd1;
			end
		end
		vx_n = vx_f;
		vy_n = vy_c;
		if (floor_hit && vy_c <= 8'sd0 && vx_f <= 8'sd1 && vx_f >= -8'sd1) begin
			vx_n = sat_vel($signed({7'b0, d_in.kick_x}), cfg.lim);
			vy_n = sat_vel($signed({7'b0, d_in.kick_y}), cfg.lim);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_in) begin
			d_s3.pos_x <= px_n;
			d_s3.pos_y <= py_n;
			d_s3.vel_x <= vx_n;
			d_s3.vel_y <= vy_n;
		end
	end

	// a freshly loaded particle respects the limit in force when it was resolved
	`PBS_CHECK_NEXT(a_vel_in_limit, adv && v_in, (d_s3.vel_x <= $past(lim_s)) && (d_s3.vel_x >= -$past(lim_s)) && (d_s3.vel_y <= $past(lim_s)) && (d_s3.vel_y >= -$past(lim_s)), "resolved velocity beyond speed limit")
	// a particle that reaches the floor is placed on the bottom row
	`PBS_CHECK_NEXT(a_floor_kick, adv && v_in && floor_hit, d_s3.pos_y == 4'(FieldMaxY), "floor particle lost its row")

endmodule

`default_nettype wire

// ----- hdl/pbs_cell.sv -----
`default_nettype none

module pbs_cell
	import pbs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     adv,
	input  wire logic     v_in,
	input  wire pbs_s3_t  d_in,
	output logic          v_out,
	output pbs_out_t      d_out
);

`include "particle_bounce_step_macros.svh"

	logic [14:0] prod;
	logic [3:0]  ccol;
	logic [6:0]  ccol_x5;
	logic [6:0]  rem;

	// x / 5 by reciprocal multiply, remainder by back-multiply
	always_comb begin
		prod    = {8'b0, d_in.pos_x} * 15'(Div5Mul);
		ccol    = prod[13:10];
		ccol_x5 = {1'b0, ccol, 2'b00} + {3'b000, ccol};
		rem     = d_in.pos_x - ccol_x5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (adv) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_in) begin
			d_out.new_pos_x  <= d_in.pos_x;
			d_out.new_pos_y  <= d_in.pos_y;
			d_out.new_vel_x  <= d_in.vel_x;
			d_out.new_vel_y  <= d_in.vel_y;
			d_out.cell_col   <= ccol;
			d_out.cell_row   <= d_in.pos_y[3];
			d_out.dot_col    <= rem[2:0];
			d_out.dot_row    <= d_in.pos_y[2:0];
			d_out.cell_index <= {d_in.pos_y[3], ccol};
		end
	end

	`PBS_CHECK(a_dot_range, !v_out || (d_out.dot_col < 3'(CellW) && d_out.new_pos_x <= 7'(FieldMaxX)), "pixel column or x out of range")

endmodule

`default_nettype wire

// ----- hdl/particle_bounce_step.sv -----
// Particle bounce step: one particle update per beat.
// Register stages, in order: gravity/clamp, move/bounce, resolve,
// cell mapping.
// Throughput: one beat per cycle; all stages advance together and hold on output stall.
// Reset: arst_n asynchronous, clears stage valids; registers return to gravity 1,
// bounce loss 1, speed limit 80.
`default_nettype none

module particle_bounce_step
	import pbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// s_tdata: pos_x[6:0], pos_y[10:7], vel_x[18:11], vel_y[26:19],
	//          kick_x[29:27], kick_y[32:30], zero fill
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,
	// m_tdata: new_pos_x[6:0], new_pos_y[10:7], new_vel_x[18:11],
	//          new_vel_y[26:19], cell_col[30:27], cell_row[31], dot_col[34:32],
	//          dot_row[37:35], cell_index[42:38], zero fill
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [6:0]  cfg_data
);

`include "particle_bounce_step_macros.svh"

	pbs_cfg_t cfg;
	pbs_in_t  d_in;
	logic     adv;
	logic     v_s2;
	pbs_s2_t  d_s2;
	logic     v_s3;
	pbs_s3_t  d_s3;
	pbs_out_t d_out;

	// whole pipe moves unless the output beat is stalled
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;
	assign d_in     = s_tdata[32:0];
	assign m_tdata  = {5'b0, d_out};

	pbs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pbs_move u_move (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (s_tvalid),
		.d_in   (d_in),
		.cfg    (cfg),
		.v_s2   (v_s2),
		.d_s2   (d_s2)
	);

	pbs_resolve u_resolve (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (v_s2),
		.d_in   (d_s2),
		.cfg    (cfg),
		.v_s3   (v_s3),
		.d_s3   (d_s3)
	);

	pbs_cell u_cell (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (v_s3),
		.d_in   (d_s3),
		.v_out  (m_tvalid),
		.d_out  (d_out)
	);

	// no input beat is taken while the output is stalled
	`PBS_CHECK(a_no_take_on_stall, !(m_tvalid && !m_tready) || !s_tready, "input taken during output stall")
	// a stalled pipe keeps its resolved stage
	`PBS_CHECK_NEXT(a_hold_s3, !adv && v_s3, v_s3 && $stable(d_s3), "stage 3 changed during stall")

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench
	import pbs_pkg::*;
();

	localparam int PIPE_LATENCY    = 4;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int LONG_HOLD       = 150;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 180;
	localparam int MAX_REPORTS     = 30;
	// index that maps to no register; writes to it must be ignored
	localparam logic [1:0] CFG_UNMAPPED = 2'd3;

	// Expected particle states and their comparison against output beats
	class particle_scoreboard;
		pbs_out_t    next_states[$];
		logic [2:0]  gravity;
		logic [2:0]  bounce_loss;
		logic [6:0]  speed_lim;
		int unsigned n_checked;
		int unsigned n_errors;
		int unsigned n_kicks;
		int unsigned n_bounces;

		function new();
			gravity     = 3'd1;
			bounce_loss = 3'd1;
			speed_lim   = 7'd80;
			n_checked   = 0;
			n_errors    = 0;
			n_kicks     = 0;
			n_bounces   = 0;
		endfunction

		function void set_register(logic [1:0] idx, logic [6:0] val);
			case (idx)
				CFG_GRAVITY: gravity = val[2:0];
				CFG_LOSS:    bounce_loss = val[2:0];
				CFG_LIMIT:   speed_lim = val;
				default: ;
			endcase
		endfunction

		function int clamp_speed(int v, int lim);
			if (v > lim)
				return lim;
			if (v < -lim)
				return -lim;
			return v;
		endfunction

		// one tick of the particle under the current register values
		function pbs_out_t step_particle(pbs_in_t p);
			int lim, loss, px, py, vx, vy, cc, cr, dc, dr, ci;
			bit hit;
			pbs_out_t r;
			lim = speed_lim;
			if (lim > VelBound)
				lim = VelBound;
			loss = int'(bounce_loss);
			px = p.pos_x;
			py = p.pos_y;
			vx = clamp_speed($signed(p.vel_x), lim);
			vy = $signed(p.vel_y);
			vy = clamp_speed(vy - int'(gravity), lim);
			hit = 1'b0;

			// move; up is positive velocity but lower row number
			px = px + vx;
			py = py - vy;

			// reflect components heading into a wall that was reached
			if (px <= 0 && vx < 0) begin
				vx = -vx - loss;
				hit = 1'b1;
			end
			if (px >= FieldMaxX && vx > 0) begin
				vx = -vx + loss;
				hit = 1'b1;
			end
			if (py <= 0 && vy > 0) begin
				vy = -vy + loss;
				hit = 1'b1;
			end
			if (py >= FieldMaxY && vy < 0) begin
				vy = -vy - loss;
				hit = 1'b1;
			end
			vx = clamp_speed(vx, lim);
			vy = clamp_speed(vy, lim);
			if (hit)
				n_bounces++;

			// keep the position on the field
			if (px < 0)
				px = 0;
			if (px > FieldMaxX)
				px = FieldMaxX;
			if (py < 0)
				py = 0;
			if (py > FieldMaxY)
				py = FieldMaxY;

			// rolling friction on the floor
			if (py >= FieldMaxY) begin
				if (vx < 0)
					vx = vx + 1;
				else if (vx > 0)
					vx = vx - 1;
			end

			// slow particle resting on the floor gets kicked
			if (vy <= 0 && vx <= 1 && vx >= -1 && py >= FieldMaxY) begin
				vx = clamp_speed(int'(p.kick_x), lim);
				vy = clamp_speed(int'(p.kick_y), lim);
				n_kicks++;
			end

			cc = px / CellW;
			cr = py / CellH;
			dc = px % CellW;
			dr = py % CellH;
			ci = cr * CellsPerRow + cc;
			r.new_pos_x  = px[6:0];
			r.new_pos_y  = py[3:0];
			r.new_vel_x  = vx[7:0];
			r.new_vel_y  = vy[7:0];
			r.cell_col   = cc[3:0];
			r.cell_row   = cr[0];
			r.dot_col    = dc[2:0];
			r.dot_row    = dr[2:0];
			r.cell_index = ci[4:0];
			return r;
		endfunction

		function void note_particle(pbs_in_t p);
			next_states.push_back(step_particle(p));
		endfunction

		function int pending();
			return next_states.size();
		endfunction

		task report(string msg);
			if (n_errors < MAX_REPORTS)
				$display("%0t ns: mismatch: %s", $time, msg);
			n_errors++;
		endtask

		task compare_field(string name, logic [7:0] got_v, logic [7:0] want_v);
			if (got_v !== want_v)
				report($sformatf("result %0d %s got %h, expected %h", n_checked, name,
					got_v, want_v));
		endtask

		task check_result(logic [47:0] beat);
			pbs_out_t got, want;
			got = beat[$bits(pbs_out_t)-1:0];
			if (next_states.size() == 0) begin
				report($sformatf("result beat %h with no particle pending", beat));
				return;
			end
			want = next_states.pop_front();
			compare_field("new_pos_x", got.new_pos_x, want.new_pos_x);
			compare_field("new_pos_y", got.new_pos_y, want.new_pos_y);
			compare_field("new_vel_x", got.new_vel_x, want.new_vel_x);
			compare_field("new_vel_y", got.new_vel_y, want.new_vel_y);
			compare_field("cell_col", got.cell_col, want.cell_col);
			compare_field("cell_row", got.cell_row, want.cell_row);
			compare_field("dot_col", got.dot_col, want.dot_col);
			compare_field("dot_row", got.dot_row, want.dot_row);
			compare_field("cell_index", got.cell_index, want.cell_index);
			compare_field("zero fill", beat[47:$bits(pbs_out_t)], 8'd0);
			n_checked++;
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;     // pos_x, pos_y, vel_x, vel_y, kick_x, kick_y, zero fill
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;          // new_pos_x, new_pos_y, new_vel_x, new_vel_y, cell_col,
	                               // cell_row, dot_col, dot_row, cell_index, zero fill
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_GRAVITY;
	logic [6:0]  cfg_data = '0;

	particle_scoreboard sb;
	int unsigned n_sent = 0;
	int unsigned n_settings = 0;
	int unsigned idle_cycles = 0;

	particle_bounce_step u_top (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Ends the run when no beat on any channel moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: nothing accepted for %0d cycles, %0d results outstanding",
				idle_cycles, sb.pending());
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: check each beat, stall at random and twice for a long stretch
	initial begin : result_sink
		int stall_left;
		bit rx_calm;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
				if (sb.n_checked == 300 || sb.n_checked == 1000)
					stall_left = LONG_HOLD;
			end
			rx_calm = (sb.n_checked % 700) >= 400 && (sb.n_checked % 700) < 550;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!rx_calm && $urandom_range(99) < 10) begin
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic pbs_in_t particle(int px, int py, int vx, int vy, int kx, int ky);
		pbs_in_t p;
		p.pos_x  = px[6:0];
		p.pos_y  = py[3:0];
		p.vel_x  = vx[7:0];
		p.vel_y  = vy[7:0];
		p.kick_x = kx[2:0];
		p.kick_y = ky[2:0];
		return p;
	endfunction

	// Random particle, biased towards floor, walls and ceiling
	function automatic pbs_in_t random_particle();
		int pick, px, py, vx, vy;
		pick = $urandom_range(99);
		if (pick < 35) begin
			// slow and near the floor: friction and kicks
			px = $urandom_range(79);
			py = $urandom_range(15, 12);
			vx = int'($urandom_range(8)) - 4;
			vy = int'($urandom_range(6)) - 3;
		end else if (pick < 60) begin
			// heading into a side wall, sometimes into the ceiling
			py = $urandom_range(15);
			vy = int'($urandom_range(40)) - 20;
			if ($urandom_range(1)) begin
				px = $urandom_range(4);
				vx = -int'($urandom_range(30));
			end else begin
				px = $urandom_range(79, 75);
				vx = $urandom_range(30);
			end
			if ($urandom_range(3) == 0) begin
				py = $urandom_range(3);
				vy = $urandom_range(30);
			end
		end else if (pick < 95) begin
			px = $urandom_range(79);
			py = $urandom_range(15);
			vx = int'($urandom_range(160)) - 80;
			vy = int'($urandom_range(160)) - 80;
		end else begin
			// raw field values, off the field and beyond the speed bound
			px = $urandom_range(127);
			py = $urandom_range(15);
			vx = $urandom_range(255);
			vy = $urandom_range(255);
		end
		return particle(px, py, vx, vy, $urandom_range(7), $urandom_range(7));
	endfunction

	task automatic send_particle(pbs_in_t p);
		s_tdata  <= {{(40 - $bits(pbs_in_t)){1'b0}}, p};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (s_tready !== 1'b1);
		sb.note_particle(p);
		n_sent++;
	endtask

	// random gap between input beats, none in a calm stretch
	task automatic maybe_idle();
		int gap;
		if (!((n_sent % 600) >= 200 && (n_sent % 600) < 350) && $urandom_range(99) < 10) begin
			gap = $urandom_range(4, 1);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// hold input until every predicted result has been checked
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_register(logic [1:0] idx, logic [6:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		sb.set_register(idx, val);
	endtask

	// new register setting; upper data bits of the 3-bit registers are junk
	task automatic configure(int g, int l, int lim);
		drain_results();
		write_register(CFG_UNMAPPED, $urandom_range(127));
		write_register(CFG_GRAVITY, g + 8 * $urandom_range(15));
		write_register(CFG_LOSS, l + 8 * $urandom_range(15));
		write_register(CFG_LIMIT, lim);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	initial begin : stimulus
		int ph, k;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset register values
		send_particle(particle(0, 0, 0, 0, 0, 0));
		send_particle(particle(127, 15, 127, 127, 7, 7));
		send_particle(particle(79, 15, -128, -128, 0, 0));
		send_particle(particle(0, 0, -80, 80, 0, 0));       // top-left corner
		send_particle(particle(79, 8, 80, 0, 0, 0));        // right wall
		send_particle(particle(40, 15, 0, 0, 5, 3));        // resting, kicked
		send_particle(particle(40, 15, 5, 0, 2, 2));        // friction only
		send_particle(particle(40, 15, -5, 0, 2, 2));
		send_particle(particle(40, 15, 2, 1, 6, 1));        // friction then kick
		send_particle(particle(100, 3, 0, 0, 0, 0));        // off the field
		send_particle(particle(10, 15, 0, -3, 4, 4));       // floor bounce
		send_particle(particle(64, 12, -7, -20, 1, 1));

		// limit above the bound, loss larger than the speed
		configure(7, 7, 127);
		send_particle(particle(1, 5, -2, 0, 0, 0));
		send_particle(particle(78, 0, 3, 9, 0, 0));
		send_particle(particle(20, 15, 1, -1, 7, 7));

		// zero limit stops everything
		configure(0, 3, 0);
		send_particle(particle(30, 7, 50, -50, 7, 7));
		send_particle(particle(30, 15, 0, 0, 7, 7));

		// kick values above a small limit
		configure(2, 1, 3);
		send_particle(particle(50, 15, 1, 0, 7, 6));
		send_particle(particle(5, 2, -80, 80, 0, 0));
		send_particle(particle(70, 10, 127, -128, 0, 0));

		// Random phases, first few at fixed extremes
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: configure(1, 1, 80);
				1: configure(0, 0, 127);
				2: configure(7, 7, 1);
				3: configure(7, 0, 80);
				4: configure(0, 7, 0);
				default: configure($urandom_range(7), $urandom_range(7), $urandom_range(127));
			endcase
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				send_particle(random_particle());
				maybe_idle();
			end
		end
		drain_results();

		$display("Stepped %0d particles under %0d register settings, speed limits 0, 1, 3, 80",
			n_sent, n_settings + 1);
		$display("and above 80; %0d floor kicks, %0d wall bounces, %0d results checked.",
			sb.n_kicks, sb.n_bounces, sb.n_checked);
		if (sb.n_errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.n_errors, sb.pending());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
